// ===== hdl/wah_bitmap_encoder_defines.svh =====
// Assertion macros shared by the bitmap encoder RTL.
`ifndef WAH_BITMAP_ENCODER_DEFINES_SVH
`define WAH_BITMAP_ENCODER_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define WBE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent in the same cycle as the antecedent.
`define WBE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define WBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wbe_pkg.sv =====
// Shared types and constants of the bitmap encoder.
`timescale 1ns / 1ps
package wbe_pkg;

  // Most code words one request can release.
  localparam int MAX_WORDS  = 4;
  // Result buffer entries; power of two, at least 3 * MAX_WORDS.
  localparam int FIFO_DEPTH = 16;

  localparam int COUNT_W = 30;
  localparam logic [1:0] FILL_ZERO = 2'b10;
  localparam logic [1:0] FILL_ONE  = 2'b11;
  localparam logic [31:0] ONE_FILL_UNIT = {FILL_ONE, 30'd1};

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic [32:0] len;
  } wbe_word_t;

  typedef struct packed {
    logic valid;
    logic final_item;
  } wbe_ctl_t;

endpackage

// ===== hdl/wbe_group_div.sv =====
// Two-stage split of a bit position into group index and offset within the group.
`timescale 1ns / 1ps
module wbe_group_div #(
  parameter int LB = 31,
  parameter int GW = 28,
  parameter int OW = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wbe_pkg::wbe_ctl_t in_ctl_i,
  input  logic [31:0]       in_position_i,
  output wbe_pkg::wbe_ctl_t grp_ctl_o,
  output logic [GW-1:0]     grp_o,
  output logic [OW-1:0]     off_o,
  output logic [32:0]       len_o,
  output logic [1:0]        busy_o
);
  import wbe_pkg::*;

  // floor(2^32 / LB): the quotient estimate is low by at most one.
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(LB));
  localparam logic [31:0] LB_W  = 32'(LB);

  wbe_ctl_t      a_ctl_q, b_ctl_q;
  logic [31:0]   a_pos_q;
  logic [GW-1:0] a_q0_q, b_grp_q, b_grp_d;
  logic [OW-1:0] b_off_q, b_off_d;
  logic [32:0]   b_len_q, b_len_d;
  logic [63:0]   prod;
  logic [31:0]   q0_mul, rem;
  logic          fix;

  assign prod = 64'(in_position_i) * 64'(RECIP);

  assign q0_mul  = 32'(a_q0_q) * LB_W;
  assign rem     = a_pos_q - q0_mul;
  assign fix     = (rem >= LB_W);
  assign b_grp_d = a_q0_q + GW'(fix);
  assign b_off_d = fix ? OW'(rem - LB_W) : OW'(rem);
  // (group + 1) * LB without a multiplier: position - offset + LB
  assign b_len_d = {1'b0, a_pos_q} - 33'(b_off_d) + 33'(LB_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q <= '0;
      b_ctl_q <= '0;
    end else begin
      a_ctl_q <= in_ctl_i;
      b_ctl_q <= a_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ctl_i.valid) begin
      a_pos_q <= in_position_i;
      a_q0_q  <= prod[32 +: GW];
    end
    if (a_ctl_q.valid) begin
      b_grp_q <= b_grp_d;
      b_off_q <= b_off_d;
      b_len_q <= b_len_d;
    end
  end

  assign grp_ctl_o = b_ctl_q;
  assign grp_o     = b_grp_q;
  assign off_o     = b_off_q;
  assign len_o     = b_len_q;
  assign busy_o    = 2'(a_ctl_q.valid) + 2'(b_ctl_q.valid);

endmodule

// ===== hdl/wbe_word_fifo.sv =====
// Result buffer: up to four writes per cycle, one read per cycle.
`timescale 1ns / 1ps
module wbe_word_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [2:0]                 push_cnt_i,
  input  wbe_pkg::wbe_word_t         push_i [wbe_pkg::MAX_WORDS],
  input  logic                       pop_i,
  output wbe_pkg::wbe_word_t         head_o,
  output logic                       valid_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  import wbe_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  wbe_word_t       mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q, count_d;

  assign count_d = count_q + CW'(push_cnt_i) - CW'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + AW'(push_cnt_i);
      rd_ptr_q <= rd_ptr_q + AW'(pop_i);
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_WORDS; k++) begin
      if (3'(k) < push_cnt_i) begin
        mem_q[wr_ptr_q + AW'(k)] <= push_i[k];
      end
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

endmodule

// ===== hdl/wah_bitmap_encoder.sv =====
// Top level of the WAH bitmap encoder: group split, run merging and result buffer.
`timescale 1ns / 1ps
`include "wah_bitmap_encoder_defines.svh"
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in      | request   | in_valid_i / in_stall_o | in_position_i, in_final_item_i
//  out     | result    | out_valid_o / out_stall_i | out_code_word_o, out_end_of_bitmap_o,
//          |           |                        | out_bit_length_o
//
// After acceptance a request passes the two divider stages, then sits in the merge stage;
// its words are written to a 16-entry buffer at the next edge, and the first word can
// leave after that. Words leave one per cycle while out_stall_i is low; a request
// makes zero to four words.
// A request is taken only while the buffer can absorb four words for it and for
// every request still in the two divider stages.
// Reset clears all control state at once; no clearing pass.
module wah_bitmap_encoder #(
  parameter int LITERAL_BITS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] in_position_i,
  input  logic        in_final_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_code_word_o,
  output logic        out_end_of_bitmap_o,
  output logic [32:0] out_bit_length_o
);
  import wbe_pkg::*;

  localparam int GW = $clog2(((64'd1 << 32) - 64'd1) / 64'(LITERAL_BITS) + 64'd1);
  localparam int OW = $clog2(LITERAL_BITS);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [LITERAL_BITS-1:0] TOP_BIT = {1'b1, {(LITERAL_BITS-1){1'b0}}};

  wbe_ctl_t          in_ctl, grp_ctl;
  logic [GW-1:0]     grp;
  logic [OW-1:0]     off;
  logic [32:0]       grp_len;
  logic [1:0]        busy;
  logic [CW-1:0]     fifo_count;
  logic [6:0]        demand;
  wbe_word_t         head;
  wbe_word_t         slots [MAX_WORDS];
  logic [2:0]        n_words;
  logic              pop;
  logic              flush;
  logic              len_tied;

  logic [GW-1:0]           cur_q, cur_d;
  logic [LITERAL_BITS-1:0] lit_q, lit_d, bit_sel;
  logic [31:0]             held_q, held_d;
  logic                    held_v_q, held_v_d;
  logic                    started_q, started_d;
  logic [32:0]             len_q, len_d;

  // reserve four words for this request and each one still in the divider
  assign demand     = 7'(fifo_count) + 7'({busy, 2'b00}) + 7'(MAX_WORDS);
  assign in_stall_o = (demand > 7'(FIFO_DEPTH));
  assign in_ctl     = '{valid: in_valid_i && !in_stall_o, final_item: in_final_item_i};

  wbe_group_div #(
    .LB(LITERAL_BITS),
    .GW(GW),
    .OW(OW)
  ) u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ctl_i      (in_ctl),
    .in_position_i (in_position_i),
    .grp_ctl_o     (grp_ctl),
    .grp_o         (grp),
    .off_o         (off),
    .len_o         (grp_len),
    .busy_o        (busy)
  );

  assign bit_sel = TOP_BIT >> off;

  always_comb begin
    cur_d     = cur_q;
    lit_d     = lit_q;
    len_d     = len_q;
    started_d = started_q;
    held_d    = held_q;
    held_v_d  = held_v_q;
    n_words   = '0;
    for (int k = 0; k < MAX_WORDS; k++) begin
      slots[k] = '0;
    end

    if (grp_ctl.valid) begin
      if (!started_q) begin
        started_d = 1'b1;
        // leading empty groups
        if (grp != '0) begin
          if (held_v_d) begin
            slots[n_words[1:0]] = '{word: held_d, last: 1'b0, len: '0};
            n_words = n_words + 3'd1;
          end
          held_d   = {FILL_ZERO, COUNT_W'(grp)};
          held_v_d = 1'b1;
        end
        cur_d = grp;
        lit_d = bit_sel;
        len_d = grp_len;
      end else if (grp == cur_q) begin
        lit_d = lit_q | bit_sel;
      end else if (grp > cur_q) begin
        // close the current literal: extend a one-fill or release a word
        if (lit_q == '1 && held_v_d && held_d[31:30] == FILL_ONE && held_d[29:0] != '1) begin
          held_d = held_d + 32'd1;
        end else begin
          if (held_v_d) begin
            slots[n_words[1:0]] = '{word: held_d, last: 1'b0, len: '0};
            n_words = n_words + 3'd1;
          end
          held_d   = (lit_q == '1) ? ONE_FILL_UNIT : 32'(lit_q);
          held_v_d = 1'b1;
        end
        // empty groups strictly between the two
        if (grp != cur_q + GW'(1)) begin
          if (held_v_d) begin
            slots[n_words[1:0]] = '{word: held_d, last: 1'b0, len: '0};
            n_words = n_words + 3'd1;
          end
          held_d   = {FILL_ZERO, COUNT_W'(grp - cur_q - GW'(1))};
          held_v_d = 1'b1;
        end
        cur_d = grp;
        lit_d = bit_sel;
        len_d = grp_len;
      end

      if (grp_ctl.final_item) begin
        if (lit_d == '1 && held_v_d && held_d[31:30] == FILL_ONE && held_d[29:0] != '1) begin
          held_d = held_d + 32'd1;
        end else begin
          if (held_v_d) begin
            slots[n_words[1:0]] = '{word: held_d, last: 1'b0, len: '0};
            n_words = n_words + 3'd1;
          end
          held_d   = (lit_d == '1) ? ONE_FILL_UNIT : 32'(lit_d);
          held_v_d = 1'b1;
        end
        slots[n_words[1:0]] = '{word: held_d, last: 1'b1, len: len_d};
        n_words = n_words + 3'd1;
        // start a fresh bitmap
        cur_d     = '0;
        lit_d     = '0;
        len_d     = '0;
        started_d = 1'b0;
        held_d    = '0;
        held_v_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      lit_q     <= '0;
      len_q     <= '0;
      started_q <= 1'b0;
      held_q    <= '0;
      held_v_q  <= 1'b0;
    end else begin
      cur_q     <= cur_d;
      lit_q     <= lit_d;
      len_q     <= len_d;
      started_q <= started_d;
      held_q    <= held_d;
      held_v_q  <= held_v_d;
    end
  end

  assign pop = out_valid_o && !out_stall_i;

  wbe_word_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (n_words),
    .push_i     (slots),
    .pop_i      (pop),
    .head_o     (head),
    .valid_o    (out_valid_o),
    .count_o    (fifo_count)
  );

  assign out_code_word_o     = head.word;
  assign out_end_of_bitmap_o = head.last;
  assign out_bit_length_o    = head.len;

  assign flush    = grp_ctl.valid && grp_ctl.final_item;
  assign len_tied = (out_end_of_bitmap_o == (out_bit_length_o != 33'd0));

  `WBE_ASSERT_ALWAYS(a_fifo_bound, fifo_count <= CW'(FIFO_DEPTH), "result buffer overflow")
  `WBE_ASSERT_IMP(a_idle_no_push, !grp_ctl.valid, n_words == 3'd0, "words without a request")
  `WBE_ASSERT_IMP(a_len_on_last, out_valid_o, len_tied, "bit length off the last word")
  `WBE_ASSERT_NEXT(a_flush_clears, flush, !started_q && !held_v_q, "state kept after flush")

endmodule
